>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the nonce replay cache.
// Standalone header; it is pulled in by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

>>> hw/rtl/nrc_pkg.sv
// Package of the nonce replay cache: widths, slot count, sequencer states and
// the status struct passed from the slot checker. No dependencies.
`default_nettype none

package nrc_pkg;

   // Slot count; must be a power of two so that now mod SLOTS is a bit slice.
   localparam int SLOTS    = 256;
   localparam int SLOT_W   = $clog2(SLOTS);
   localparam int NONCE_W  = 64;
   localparam int TIME_W   = 32;
   localparam int SKEW_W   = 16;
   localparam int OSLOT_W  = 8;

   localparam logic [SKEW_W-1:0] SKEW_RESET = SKEW_W'(30);
   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(SLOTS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_FINISH
   } seq_state_type;

   typedef struct packed {
      logic live;
      logic hit;
   } slot_status_type;

endpackage

`default_nettype wire

>>> hw/rtl/nrc_channels.sv
// Valid/ready channel interfaces of the nonce replay cache: request,
// response and register write. Depends on nrc_pkg.
`default_nettype none

interface nrc_req_if;
   import nrc_pkg::*;
   logic               valid;
   logic               ready;
   logic [NONCE_W-1:0] nonce_high;
   logic [NONCE_W-1:0] nonce_low;
   logic [TIME_W-1:0]  now_seconds;
   modport source (output valid, nonce_high, nonce_low, now_seconds, input ready);
   modport sink   (input valid, nonce_high, nonce_low, now_seconds, output ready);
endinterface

interface nrc_rsp_if;
   import nrc_pkg::*;
   logic               valid;
   logic               ready;
   logic               replayed;
   logic [OSLOT_W-1:0] stored_slot;
   logic               evicted_live;
   modport source (output valid, replayed, stored_slot, evicted_live, input ready);
   modport sink   (input valid, replayed, stored_slot, evicted_live, output ready);
endinterface

interface nrc_csr_if;
   import nrc_pkg::*;
   logic              valid;
   logic              ready;
   logic [SKEW_W-1:0] skew_seconds;
   modport source (output valid, skew_seconds, input ready);
   modport sink   (input valid, skew_seconds, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/nrc_slot_check.sv
// Shared compare unit of the nonce replay cache: decides whether one slot
// read from the tables is live and holds the searched nonce. Uses nrc_pkg.
`default_nettype none

module nrc_slot_check (
   input  wire logic                         slot_valid,
   input  wire logic [nrc_pkg::TIME_W-1:0]   slot_expiry,
   input  wire logic [nrc_pkg::NONCE_W-1:0]  slot_high,
   input  wire logic [nrc_pkg::NONCE_W-1:0]  slot_low,
   input  wire logic [nrc_pkg::TIME_W-1:0]   now_seconds,
   input  wire logic [nrc_pkg::NONCE_W-1:0]  key_high,
   input  wire logic [nrc_pkg::NONCE_W-1:0]  key_low,
   output nrc_pkg::slot_status_type          status
);
   import nrc_pkg::*;

   // A slot never written has its valid bit clear, so it is never live.
   always_comb begin
      status.live = slot_valid && (slot_expiry > now_seconds);
      status.hit  = status.live && (slot_high == key_high) && (slot_low == key_low);
   end

endmodule

`default_nettype wire

>>> hw/rtl/nonce_replay_cache.sv
// Top level of the nonce replay cache: sequencer, slot tables and channels.
// Depends on nrc_pkg, nrc_channels, nrc_slot_check and assert_macros.svh.
//
// Each request beat carries a 128-bit nonce and the current time in seconds.
// The block walks all SLOTS slots in order, one table read per cycle, through
// a single compare unit. A live slot (expiry later than now) holding the same
// nonce ends the walk at once and yields a response beat with replayed set.
// Otherwise the nonce goes to the lowest expired slot, or to slot now mod
// SLOTS when every slot is live (evicted_live is then set), and that slot's
// expiry becomes now plus twice skew_seconds, clamped at the largest time.
// A fresh nonce goes through SLOTS table reads, the registered read data,
// one table write and the load of the output register, which waits while
// an earlier response is still held; a replay finishes as soon as the
// matching slot has been compared. The walk over the single-port tables
// sets the time taken. Only one request is in work at a time; the
// response sits in its own register, so the next request is accepted while
// an earlier response still waits. The expiry table is cleared by one valid
// bit per slot at reset, so there is no clearing pass. The skew register is
// written through its own port, which is always ready; write it only while
// no request is in work.
`default_nettype none

`include "assert_macros.svh"

module nonce_replay_cache (
   input  wire logic clock,
   input  wire logic reset,
   nrc_req_if.sink   req_bus,
   nrc_rsp_if.source rsp_bus,
   nrc_csr_if.sink   csr_bus
);
   import nrc_pkg::*;

   // Slot tables. Nonce halves have no reset; expiry is qualified by a
   // valid bit per slot so that reset clears the whole table.
   logic [NONCE_W-1:0] high_mem [SLOTS];
   logic [NONCE_W-1:0] low_mem  [SLOTS];
   logic [TIME_W-1:0]  exp_mem  [SLOTS];
   logic [SLOTS-1:0]   slot_valid_ff, slot_valid_in;

   // Registered read data of the table walk.
   logic [NONCE_W-1:0] rd_high_ff;
   logic [NONCE_W-1:0] rd_low_ff;
   logic [TIME_W-1:0]  rd_exp_ff;
   logic               rd_valid_ff;

   // Sequencer and walk state.
   seq_state_type      state_ff, state_in;
   logic [SLOT_W-1:0]  issue_ff, issue_in;
   logic               issuing_ff, issuing_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [SLOT_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic               have_free_ff, have_free_in;
   logic [SLOT_W-1:0]  target_ff, target_in;

   // Latched request.
   logic [NONCE_W-1:0] key_high_ff, key_high_in;
   logic [NONCE_W-1:0] key_low_ff, key_low_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [TIME_W-1:0]  new_exp_ff, new_exp_in;

   // Pending result and output register.
   logic               res_replayed_ff, res_replayed_in;
   logic [OSLOT_W-1:0] res_slot_ff, res_slot_in;
   logic               res_evict_ff, res_evict_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_replayed_ff, rsp_replayed_in;
   logic [OSLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic               rsp_evict_ff, rsp_evict_in;

   logic [SKEW_W-1:0]  skew_ff, skew_in;

   // Sequencer outputs.
   logic               req_take;
   logic               rd_en;
   logic               wr_en;
   logic               load_rsp;

   slot_status_type    status;
   logic [TIME_W:0]    exp_sum;

   nrc_slot_check u_check (
      .slot_valid  (rd_valid_ff),
      .slot_expiry (rd_exp_ff),
      .slot_high   (rd_high_ff),
      .slot_low    (rd_low_ff),
      .now_seconds (now_ff),
      .key_high    (key_high_ff),
      .key_low     (key_low_ff),
      .status      (status)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cmp_valid_ff && status.hit) begin
               state_in = ST_FINISH;
            end else if (cmp_valid_ff && (cmp_idx_ff == LAST_SLOT)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_take = 1'b0;
      rd_en    = 1'b0;
      wr_en    = 1'b0;
      load_rsp = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_take = 1'b1;
         ST_SCAN:   rd_en    = issuing_ff;
         ST_WRITE:  wr_en    = 1'b1;
         ST_FINISH: load_rsp = !rsp_valid_ff || rsp_bus.ready;
         default: begin
            req_take = 1'b0;
         end
      endcase
   end

   assign req_bus.ready = req_take;
   assign csr_bus.ready = 1'b1;

   // New expiry: now plus twice the skew, clamped to the largest time value.
   assign exp_sum = {1'b0, req_bus.now_seconds}
                  + (TIME_W + 1)'({skew_ff, 1'b0});

   // Datapath next values.
   always_comb begin
      issue_in        = issue_ff;
      issuing_in      = issuing_ff;
      cmp_valid_in    = rd_en;
      cmp_idx_in      = issue_ff;
      have_free_in    = have_free_ff;
      target_in       = target_ff;
      key_high_in     = key_high_ff;
      key_low_in      = key_low_ff;
      now_in          = now_ff;
      new_exp_in      = new_exp_ff;
      res_replayed_in = res_replayed_ff;
      res_slot_in     = res_slot_ff;
      res_evict_in    = res_evict_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_replayed_in = rsp_replayed_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_evict_in    = rsp_evict_ff;
      skew_in         = skew_ff;
      slot_valid_in   = slot_valid_ff;

      if (csr_bus.valid) begin
         skew_in = csr_bus.skew_seconds;
      end

      if (req_take && req_bus.valid) begin
         key_high_in  = req_bus.nonce_high;
         key_low_in   = req_bus.nonce_low;
         now_in       = req_bus.now_seconds;
         new_exp_in   = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];
         issue_in     = '0;
         issuing_in   = 1'b1;
         have_free_in = 1'b0;
         // Fallback slot when every slot is live: now mod SLOTS.
         target_in    = req_bus.now_seconds[SLOT_W-1:0];
      end

      if (rd_en) begin
         issue_in = issue_ff + SLOT_W'(1);
         if (issue_ff == LAST_SLOT) begin
            issuing_in = 1'b0;
         end
      end

      if ((state_ff == ST_SCAN) && cmp_valid_ff) begin
         if (status.hit) begin
            res_replayed_in = 1'b1;
            res_slot_in     = '0;
            res_evict_in    = 1'b0;
         end else if (!status.live && !have_free_ff) begin
            have_free_in = 1'b1;
            target_in    = cmp_idx_ff;
         end
      end

      if (wr_en) begin
         slot_valid_in[target_ff] = 1'b1;
         res_replayed_in          = 1'b0;
         res_slot_in              = OSLOT_W'(target_ff);
         res_evict_in             = !have_free_ff;
      end

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in    = 1'b1;
         rsp_replayed_in = res_replayed_ff;
         rsp_slot_in     = res_slot_ff;
         rsp_evict_in    = res_evict_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issuing_ff    <= 1'b0;
         cmp_valid_ff  <= 1'b0;
         have_free_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skew_ff       <= SKEW_RESET;
         slot_valid_ff <= '0;
      end else begin
         state_ff      <= state_in;
         issuing_ff    <= issuing_in;
         cmp_valid_ff  <= cmp_valid_in;
         have_free_ff  <= have_free_in;
         rsp_valid_ff  <= rsp_valid_in;
         skew_ff       <= skew_in;
         slot_valid_ff <= slot_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      issue_ff        <= issue_in;
      cmp_idx_ff      <= cmp_idx_in;
      target_ff       <= target_in;
      key_high_ff     <= key_high_in;
      key_low_ff      <= key_low_in;
      now_ff          <= now_in;
      new_exp_ff      <= new_exp_in;
      res_replayed_ff <= res_replayed_in;
      res_slot_ff     <= res_slot_in;
      res_evict_ff    <= res_evict_in;
      rsp_replayed_ff <= rsp_replayed_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_evict_ff    <= rsp_evict_in;
   end

   // Table port: one registered read during the walk, one write afterwards.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_high_ff  <= high_mem[issue_ff];
         rd_low_ff   <= low_mem[issue_ff];
         rd_exp_ff   <= exp_mem[issue_ff];
         rd_valid_ff <= slot_valid_ff[issue_ff];
      end
      if (wr_en) begin
         high_mem[target_ff] <= key_high_ff;
         low_mem[target_ff]  <= key_low_ff;
         exp_mem[target_ff]  <= new_exp_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.replayed     = rsp_replayed_ff;
   assign rsp_bus.stored_slot  = rsp_slot_ff;
   assign rsp_bus.evicted_live = rsp_evict_ff;

   // A replay never reports a slot or an eviction.
   `ASSERT_IMPLIES(a_replay_clean, clock, reset,
      rsp_valid_ff && rsp_replayed_ff, (rsp_slot_ff == '0) && !rsp_evict_ff)

   // With no expired slot found, the write goes to now mod SLOTS.
   `ASSERT_IMPLIES(a_evict_target, clock, reset,
      (state_ff == ST_WRITE) && !have_free_ff, target_ff == now_ff[SLOT_W-1:0])

   // An accepted request starts the walk in the next cycle.
   `ASSERT_NEXT(a_accept_scan, clock, reset,
      req_bus.valid && req_take, (state_ff == ST_SCAN) && issuing_ff && (issue_ff == '0))

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the nonce replay cache: random and directed request beats,
// a predicting scoreboard, and stalls on both channels. Depends on nrc_pkg, nrc_channels
// and the nonce_replay_cache RTL.
`default_nettype none

module tb_top;
   import nrc_pkg::*;

   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 5;
   // The long response hold-off spans several fresh lookups, so the cache
   // fills its output register, then its single work slot, and stops taking
   // requests.
   localparam int LONG_HOLD    = 1200;
   // The watchdog limit covers the long hold-off plus one full walk, several times over.
   localparam int STALL_LIMIT  = 6000;
   // Quiet time after the last response, a bit more than one full walk.
   localparam int DRAIN_CYCLES = 300;
   localparam int POOL_DEPTH   = 48;

   localparam logic [NONCE_W-1:0] ALL_ONES = '1;

   // One expected or observed response beat.
   typedef struct packed {
      logic               replayed;
      logic [OSLOT_W-1:0] stored_slot;
      logic               evicted_live;
   } verdict_type;

   // Scoreboard. It keeps a private copy of the slot tables and the skew
   // register. For every accepted request it replays the slot walk, and it
   // checks response beats in order against the verdicts it has queued.
   class replay_scoreboard;
      logic [NONCE_W-1:0] held_high [SLOTS];
      logic [NONCE_W-1:0] held_low  [SLOTS];
      logic [TIME_W-1:0]  expiry    [SLOTS];
      logic [SKEW_W-1:0]  skew;
      verdict_type        awaited [$];
      int                 errors;

      function new();
         foreach (expiry[i]) begin
            expiry[i]    = '0;
            held_high[i] = '0;
            held_low[i]  = '0;
         end
         skew   = SKEW_RESET;
         errors = 0;
      endfunction

      function void set_skew(logic [SKEW_W-1:0] value);
         skew = value;
      endfunction

      function void note_request(logic [NONCE_W-1:0] hi, logic [NONCE_W-1:0] lo,
                                 logic [TIME_W-1:0] now);
         verdict_type     verdict;
         logic [TIME_W:0] expires;
         int              target;
         int              i;
         bit              have_free;
         verdict   = '0;
         target    = 0;
         have_free = 1'b0;
         for (i = 0; i < SLOTS; i++) begin
            // A live slot with the same nonce ends the walk as a replay.
            if (expiry[i] > now && held_high[i] == hi && held_low[i] == lo) begin
               verdict.replayed = 1'b1;
               awaited.push_back(verdict);
               return;
            end
            if (!(expiry[i] > now) && !have_free) begin
               have_free = 1'b1;
               target    = i;
            end
         end
         // With every slot live, the slot index comes from the time.
         if (!have_free)
            target = now % SLOTS;
         expires = (TIME_W+1)'(now) + (TIME_W+1)'(skew) + (TIME_W+1)'(skew);
         held_high[target] = hi;
         held_low[target]  = lo;
         expiry[target]    = expires[TIME_W] ? ALL_ONES[TIME_W-1:0] : expires[TIME_W-1:0];
         verdict.stored_slot  = OSLOT_W'(target);
         verdict.evicted_live = !have_free;
         awaited.push_back(verdict);
      endfunction

      function void compare(string field, logic [OSLOT_W-1:0] want, logic [OSLOT_W-1:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_response(verdict_type got);
         verdict_type want;
         if (awaited.size() == 0) begin
            $display("%0t: response beat with nothing expected: replayed=%0d",
                     $time, got.replayed,
                     " stored_slot=%0d evicted_live=%0d",
                     got.stored_slot, got.evicted_live);
            errors++;
            return;
         end
         want = awaited.pop_front();
         compare("replayed", want.replayed, got.replayed);
         compare("stored_slot", want.stored_slot, got.stored_slot);
         compare("evicted_live", want.evicted_live, got.evicted_live);
      endfunction
   endclass

   logic clock;
   logic reset;

   nrc_req_if req_bus ();
   nrc_rsp_if rsp_bus ();
   nrc_csr_if csr_bus ();

   nonce_replay_cache dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   replay_scoreboard ledger = new();

   // quiet turns off the random gaps on both channels. hold_pending asks the
   // receiver for one long hold-off, which it times on its own.
   bit                 quiet;
   bit                 hold_pending;
   logic [TIME_W-1:0]  wall_clock;
   logic [127:0]       nonce_pool [$];

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // The receiver changes ready on the falling edge. It makes short random
   // stall bursts, and on request one long hold-off.
   initial begin : receiver
      int stall_left;
      rsp_bus.ready = 1'b0;
      stall_left    = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else if (hold_pending) begin
            hold_pending  = 1'b0;
            rsp_bus.ready = 1'b0;
            stall_left    = LONG_HOLD - 1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready = 1'b0;
            stall_left    = $urandom_range(0, 12);
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // The monitor samples response beats on the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         ledger.check_response(verdict_type'({rsp_bus.replayed, rsp_bus.stored_slot,
                                              rsp_bus.evicted_live}));
   end

   // The watchdog stops a run in which no beat moves on any channel for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
             (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // Sends one request beat. An optional gap comes first. Valid stays high
   // after the beat is accepted, so the next action on the channel, which
   // always starts at a falling edge, either replaces the beat or drops valid.
   task automatic send_request(logic [NONCE_W-1:0] hi, logic [NONCE_W-1:0] lo,
                               logic [TIME_W-1:0] now);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         @(negedge clock);
         req_bus.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid       = 1'b1;
      req_bus.nonce_high  = hi;
      req_bus.nonce_low   = lo;
      req_bus.now_seconds = now;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      ledger.note_request(hi, lo, now);
   endtask

   // Drops valid and waits until every expected response has arrived. The
   // block keeps only one request in work, so it is idle after that.
   task automatic settle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (ledger.awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes the skew register while the cache is idle.
   task automatic write_skew(logic [SKEW_W-1:0] value);
      settle();
      @(negedge clock);
      csr_bus.valid        = 1'b1;
      csr_bus.skew_seconds = value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      ledger.set_skew(value);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // One random phase at a fixed skew. A share of the nonces repeat recent
   // ones, so replays happen. Time mostly creeps forward, so entries live
   // for a while, and on wide phases it sometimes jumps anywhere.
   task automatic run_phase(int count, logic [SKEW_W-1:0] skew, int repeat_pct,
                            int step_max, bit wide_time, int hold_at, int quiet_from);
      logic [127:0] nonce;
      int           k;
      write_skew(skew);
      quiet = 1'b0;
      for (k = 0; k < count; k++) begin
         if (k == hold_at)
            hold_pending = 1'b1;
         if (k == quiet_from)
            quiet = 1'b1;
         if (nonce_pool.size() != 0 && $urandom_range(0, 99) < repeat_pct) begin
            nonce = nonce_pool[$urandom_range(0, nonce_pool.size() - 1)];
         end else begin
            nonce = {$urandom, $urandom, $urandom, $urandom};
            nonce_pool.push_back(nonce);
            if (nonce_pool.size() > POOL_DEPTH)
               void'(nonce_pool.pop_front());
         end
         if (wide_time && $urandom_range(0, 9) == 0)
            wall_clock = $urandom;
         else
            wall_clock += $urandom_range(0, step_max);
         send_request(nonce[127:64], nonce[63:0], wall_clock);
      end
   endtask

   initial begin : main
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.nonce_high   = '0;
      req_bus.nonce_low    = '0;
      req_bus.now_seconds  = '0;
      csr_bus.valid        = 1'b0;
      csr_bus.skew_seconds = '0;
      quiet                = 1'b0;
      hold_pending         = 1'b0;
      wall_clock           = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset skew of 30 seconds, so entries live 60.
      // A zero nonce is stored, replayed, then stored again when its expiry
      // equals now.
      send_request('0, '0, 32'd0);
      send_request('0, '0, 32'd59);
      send_request('0, '0, 32'd60);
      // An all-ones nonce and nonces that differ from it in one half only.
      send_request(ALL_ONES, ALL_ONES, 32'd61);
      send_request(ALL_ONES, '0, 32'd62);
      send_request('0, ALL_ONES, 32'd62);
      send_request(ALL_ONES, ALL_ONES, 32'd120);
      // At the largest time nothing is live, and the new expiry saturates.
      // The saturated entry then stays live for any smaller time.
      send_request(ALL_ONES, ALL_ONES, ALL_ONES[TIME_W-1:0]);
      send_request(ALL_ONES, ALL_ONES, ALL_ONES[TIME_W-1:0]);
      send_request(ALL_ONES, ALL_ONES, 32'd5);

      // With zero skew an entry expires at once and never matches.
      write_skew('0);
      send_request(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 32'd1000);
      send_request(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 32'd1000);

      // The largest skew saturates the expiry close to the end of time.
      write_skew(ALL_ONES[SKEW_W-1:0]);
      send_request(64'h5a5a_5a5a_a5a5_a5a5, 64'h3c3c_c3c3_0f0f_f0f0, 32'hffff_0000);
      send_request(64'h5a5a_5a5a_a5a5_a5a5, 64'h3c3c_c3c3_0f0f_f0f0, 32'hffff_fffe);
      send_request({$urandom, $urandom}, {$urandom, $urandom}, 32'h1234_5678);

      // A skew of one second gives a two-second lifetime.
      write_skew(16'd1);
      send_request(64'h8000_0000_0000_0001, 64'h0000_0001_8000_0000, 32'd500);
      send_request(64'h8000_0000_0000_0001, 64'h0000_0001_8000_0000, 32'd501);
      send_request(64'h8000_0000_0000_0001, 64'h0000_0001_8000_0000, 32'd502);

      // Moderate skew with many repeats. Early in this phase the receiver
      // holds off for a long time while requests keep coming.
      wall_clock = 32'd10000;
      run_phase(140, 16'($urandom_range(20, 200)), 40, 60, 1'b0, 20, 140);
      // Largest skew with slowly moving time fills the whole table. After
      // that, live entries are evicted. The second half runs without gaps.
      run_phase(330, ALL_ONES[SKEW_W-1:0], 10, 2, 1'b0, -1, 165);
      // Tiny skews with time jumps anywhere.
      run_phase(60, 16'($urandom_range(0, 3)), 50, 4, 1'b1, -1, 60);
      // Last part: random skew and no idling on either side.
      run_phase(60, 16'($urandom_range(0, 65535)), 40, 1000, 1'b1, -1, 0);

      @(negedge clock);
      req_bus.valid = 1'b0;
      while (ledger.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.errors == 0 && ledger.awaited.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
